FILE: rtl/core/sbeh_pkg.sv
// Package for the swept box earliest hit block: payload types, constants and
// controller state encoding. Depends on nothing.
`default_nettype none
package sbeh_pkg;
	localparam int CoordW    = 24;
	localparam int TimeW     = 19;
	localparam int OutTimeW  = 17;
	localparam int PosW      = 16;
	localparam int MaxTargets = 65536;
	localparam int PosCapInt = (MaxTargets - 1) < 65535 ? (MaxTargets - 1) : 65535;
	localparam logic [PosW-1:0] PosCap = PosCapInt[PosW-1:0];
	localparam logic signed [TimeW-1:0] TimeLimit = 19'sd131072;
	localparam logic signed [TimeW-1:0] TimeOne   = 19'sd65536;
	localparam int DivNumW  = 42;
	localparam int DivCntW  = 6;

	typedef struct packed {
		logic signed [CoordW-1:0] mover_min_x;
		logic signed [CoordW-1:0] mover_min_y;
		logic signed [CoordW-1:0] mover_max_x;
		logic signed [CoordW-1:0] mover_max_y;
		logic signed [CoordW-1:0] velocity_x;
		logic signed [CoordW-1:0] velocity_y;
		logic signed [CoordW-1:0] target_min_x;
		logic signed [CoordW-1:0] target_min_y;
		logic signed [CoordW-1:0] target_max_x;
		logic signed [CoordW-1:0] target_max_y;
		logic                     last_target;
	} req_t;

	typedef struct packed {
		logic                hit_found;
		logic [OutTimeW-1:0] hit_time;
		logic                normal_on_y;
		logic                normal_negative;
		logic [PosW-1:0]     target_index;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_START, ST_DIV, ST_NEXT, ST_EVAL, ST_OUT
	} state_t;

	typedef struct packed {
		logic       load;
		logic       div_start;
		logic [1:0] div_sel;
		logic       eval;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic last;
	} sts_t;
endpackage
`default_nettype wire

FILE: rtl/core/sbeh_if.sv
// Valid/ready channel interface carrying one payload.
// Payload type is given by the instantiating module.
`default_nettype none
interface sbeh_if #(parameter type payload_t = logic) (input logic clk);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/swept_box_earliest_hit.sv
// Top level of the swept box earliest hit block.
// Uses sbeh_pkg, sbeh_if, sbeh_ctrl and sbeh_datapath.
//
// Requests arrive on the req channel, one target box per request, with the
// moving box and its velocity. Each request takes four signed divisions on
// one shared radix-2 divider of 42 steps. Only a request marked last_target
// produces a result on the rsp channel, registered at its evaluation; it
// holds the earliest hit of the run. The result sits in an output register,
// so the next request is accepted while it waits; if a further last request
// finishes before the receiver takes the result, the block waits.
// Reset clears the run state and any pending result.
`default_nettype none
module swept_box_earliest_hit (
	input wire logic clk,
	input wire logic arst_n,
	sbeh_if.sink   req,
	sbeh_if.source rsp
);
	import sbeh_pkg::*;
	cmd_t cmd;
	sts_t sts;

	sbeh_ctrl u_ctrl (.clk, .arst_n, .in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready), .sts, .cmd);

	sbeh_datapath u_dp (.clk, .arst_n, .cmd, .req(req.data), .sts, .rsp_q(rsp.data));
endmodule
`default_nettype wire

FILE: rtl/core/sbeh_div.sv
// Radix-2 restoring signed divider with saturation to the time limits.
// Uses sbeh_pkg.
`default_nettype none
module sbeh_div (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic signed [sbeh_pkg::CoordW:0] span,
	input  wire logic signed [sbeh_pkg::CoordW-1:0] vel,
	output logic done,
	output logic signed [sbeh_pkg::TimeW-1:0] quot
);
	import sbeh_pkg::*;
	logic [DivNumW-1:0] rem_q, num_q;
	logic [CoordW-1:0]  den_q;
	logic               neg_q, busy_q;
	logic [DivCntW-1:0] cnt_q;
	logic [DivNumW-1:0] trial;
	logic [DivNumW-1:0] dabs;
	logic [CoordW-1:0]  vabs;
	logic               sat;
	logic signed [TimeW:0] sq;

	assign dabs = span[CoordW] ? DivNumW'(-{{(DivNumW-CoordW-17){span[CoordW]}}, span, 16'd0})
		: DivNumW'({span, 16'd0});
	assign vabs = vel[CoordW-1] ? -vel : vel;
	assign trial = {rem_q[DivNumW-2:0], num_q[DivNumW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= DivCntW'(DivNumW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DivCntW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= dabs;
			den_q <= vabs;
			neg_q <= span[CoordW] ^ vel[CoordW-1];
		end else if (busy_q) begin
			num_q <= {num_q[DivNumW-2:0], 1'b0};
			if (trial >= DivNumW'(den_q)) begin
				rem_q <= trial - DivNumW'(den_q);
				num_q <= {num_q[DivNumW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
			end
		end
	end

	assign sat = num_q > DivNumW'(TimeLimit);
	assign sq = sat ? (TimeW+1)'(TimeLimit) : (TimeW+1)'(num_q[TimeW-1:0]);
	assign quot = neg_q ? TimeW'(-sq) : TimeW'(sq);
endmodule
`default_nettype wire

FILE: rtl/core/sbeh_datapath.sv
// Datapath: operand capture, shared divider, slab decision and best-hit store.
// Uses sbeh_pkg and sbeh_div.
`default_nettype none
module sbeh_datapath (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire sbeh_pkg::cmd_t cmd,
	input  wire sbeh_pkg::req_t req,
	output sbeh_pkg::sts_t sts,
	output sbeh_pkg::rsp_t rsp_q
);
	import sbeh_pkg::*;
	req_t r_q;
	logic signed [TimeW-1:0] t_q [4];
	logic signed [CoordW:0] span;
	logic signed [CoordW-1:0] vel;
	logic signed [TimeW-1:0] quot;
	logic div_done;
	logic best_valid_q, best_on_y_q, best_neg_q;
	logic [OutTimeW-1:0] best_time_q;
	logic [PosW-1:0] best_pos_q, pos_q;
	logic okx, oky, hit, on_x;
	logic signed [TimeW-1:0] xe, xx, ye, yx, entry, ext;
	logic [OutTimeW-1:0] tv;

	always_comb begin
		case (cmd.div_sel)
			2'd0: begin
				vel = r_q.velocity_x;
				span = r_q.velocity_x[CoordW-1] ? (r_q.target_max_x - r_q.mover_min_x)
					: (r_q.target_min_x - r_q.mover_max_x);
			end
			2'd1: begin
				vel = r_q.velocity_x;
				span = r_q.velocity_x[CoordW-1] ? (r_q.target_min_x - r_q.mover_max_x)
					: (r_q.target_max_x - r_q.mover_min_x);
			end
			2'd2: begin
				vel = r_q.velocity_y;
				span = r_q.velocity_y[CoordW-1] ? (r_q.target_max_y - r_q.mover_min_y)
					: (r_q.target_min_y - r_q.mover_max_y);
			end
			default: begin
				vel = r_q.velocity_y;
				span = r_q.velocity_y[CoordW-1] ? (r_q.target_min_y - r_q.mover_max_y)
					: (r_q.target_max_y - r_q.mover_min_y);
			end
		endcase
	end

	sbeh_div u_div (.clk, .arst_n, .start(cmd.div_start), .span, .vel,
		.done(div_done), .quot);

	always_ff @(posedge clk) begin
		if (cmd.load) r_q <= req;
		if (div_done) t_q[cmd.div_sel] <= quot;
	end

	always_comb begin
		okx = !(r_q.mover_max_x <= r_q.target_min_x || r_q.mover_min_x >= r_q.target_max_x);
		oky = !(r_q.mover_max_y <= r_q.target_min_y || r_q.mover_min_y >= r_q.target_max_y);
		xe = (r_q.velocity_x == '0) ? -TimeLimit : t_q[0];
		xx = (r_q.velocity_x == '0) ? TimeLimit : t_q[1];
		ye = (r_q.velocity_y == '0) ? -TimeLimit : t_q[2];
		yx = (r_q.velocity_y == '0) ? TimeLimit : t_q[3];
		on_x = xe > ye;
		entry = on_x ? xe : ye;
		ext = (xx < yx) ? xx : yx;
		hit = (r_q.velocity_x != '0 || okx) && (r_q.velocity_y != '0 || oky)
			&& !(entry > ext) && !(entry > TimeOne) && !(ext <= 0)
			&& !(xe > TimeOne) && !(ye > TimeOne);
		tv = entry[TimeW-1] ? '0 : entry[OutTimeW-1:0];
	end

	assign sts = '{div_done: div_done, last: r_q.last_target};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_valid_q <= 1'b0;
			best_time_q <= '0;
			best_on_y_q <= 1'b0;
			best_neg_q <= 1'b0;
			best_pos_q <= '0;
			pos_q <= '0;
		end else if (cmd.eval) begin
			if (r_q.last_target) begin
				best_valid_q <= 1'b0;
				best_time_q <= '0;
				best_on_y_q <= 1'b0;
				best_neg_q <= 1'b0;
				best_pos_q <= '0;
				pos_q <= '0;
			end else begin
				if (pos_q < PosCap) pos_q <= pos_q + 1'b1;
				if (hit && (!best_valid_q || tv < best_time_q)) begin
					best_valid_q <= 1'b1;
					best_time_q <= tv;
					best_on_y_q <= !on_x;
					best_neg_q <= on_x ? (r_q.velocity_x > 0) : (r_q.velocity_y > 0);
					best_pos_q <= pos_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (hit && (!best_valid_q || tv < best_time_q)) begin
				rsp_q <= '{1'b1, tv, !on_x,
					on_x ? (r_q.velocity_x > 0) : (r_q.velocity_y > 0), pos_q};
			end else if (best_valid_q) begin
				rsp_q <= '{1'b1, best_time_q, best_on_y_q, best_neg_q, best_pos_q};
			end else begin
				rsp_q <= '0;
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/sbeh_ctrl.sv
// Controller state machine sequencing the four divisions and the result.
// Uses sbeh_pkg.
`default_nettype none
module sbeh_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  wire logic out_ready,
	input  wire sbeh_pkg::sts_t sts,
	output sbeh_pkg::cmd_t cmd
);
	import sbeh_pkg::*;
	state_t state_q, state_d;
	logic [1:0] sel_q;
	logic ov_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_START;
			ST_START: state_d = ST_DIV;
			ST_DIV:   if (sts.div_done) state_d = ST_NEXT;
			ST_NEXT:  state_d = (sel_q == 2'd3) ? ST_EVAL : ST_START;
			ST_EVAL:  state_d = (sts.last && ov_q && !out_ready) ? ST_EVAL : ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		cmd.div_sel = sel_q;
		case (state_q)
			ST_IDLE:  begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_START: cmd.div_start = 1'b1;
			ST_EVAL:  begin
				if (!(sts.last && ov_q && !out_ready)) begin
					cmd.eval = 1'b1;
					cmd.out_load = sts.last;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q <= 2'd0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_NEXT) sel_q <= sel_q + 1'b1;
			if (cmd.out_load) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	assign out_valid = ov_q;

`ifndef SYNTH
	a_sel_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> sel_q == 2'd0) else $error("divider select not at start");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !ov_q || out_ready) else $error("result overwritten");
	a_eval_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.eval |=> !cmd.eval) else $error("double evaluation");
`endif
endmodule
`default_nettype wire

FILE: tb/tb_sbeh_checker.sv
// Checker for the swept box earliest hit block: predicts each run's result and
// compares it with the rsp channel. Depends on sbeh_pkg.
`default_nettype none
module tb_sbeh_checker
	import sbeh_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	input  wire logic req_ready,
	input  wire req_t req_data,
	input  wire logic rsp_valid,
	input  wire logic rsp_ready,
	input  wire rsp_t rsp_data,
	output int        fail_count,
	output int        pending
);
	localparam longint Limit = 131072;
	localparam longint One   = 65536;

	rsp_t   expected_q[$];
	logic   run_valid;
	longint run_time;
	logic   run_on_y;
	logic   run_negative;
	int     run_position;
	int     target_count;

	assign pending = expected_q.size();

	function automatic longint slab_time(input longint span, input longint vel);
		longint q;
		q = (span * 65536) / vel;
		if (q > Limit) q = Limit;
		if (q < -Limit) q = -Limit;
		return q;
	endfunction

	function automatic logic slab(input longint mn, input longint mx, input longint v,
			input longint tn, input longint tx, output longint t_in, output longint t_out);
		t_in = 0;
		t_out = 0;
		if (v == 0) begin
			if (mx <= tn || mn >= tx) return 1'b0;
			t_in = -Limit;
			t_out = Limit;
		end else if (v > 0) begin
			t_in = slab_time(tn - mx, v);
			t_out = slab_time(tx - mn, v);
		end else begin
			t_in = slab_time(tx - mn, v);
			t_out = slab_time(tn - mx, v);
		end
		return 1'b1;
	endfunction

	task automatic predict_hit(input req_t r);
		longint xe, xx, ye, yx, t_in, t_out;
		logic   hit, on_x;
		rsp_t   res;
		hit = slab(r.mover_min_x, r.mover_max_x, r.velocity_x, r.target_min_x,
			r.target_max_x, xe, xx);
		if (hit)
			hit = slab(r.mover_min_y, r.mover_max_y, r.velocity_y, r.target_min_y,
				r.target_max_y, ye, yx);
		if (hit) begin
			t_in = xe > ye ? xe : ye;
			t_out = xx < yx ? xx : yx;
			if (t_in > t_out || t_in > One || t_out <= 0 || xe > One || ye > One)
				hit = 1'b0;
			if (hit) begin
				if (t_in < 0) t_in = 0;
				on_x = xe > ye;
				if (!run_valid || t_in < run_time) begin
					run_valid = 1'b1;
					run_time = t_in;
					run_on_y = !on_x;
					run_negative = on_x ? (r.velocity_x > 0) : (r.velocity_y > 0);
					run_position = target_count;
				end
			end
		end
		if (!r.last_target) begin
			if (target_count < int'(PosCap)) target_count++;
		end else begin
			res.hit_found = run_valid;
			res.hit_time = run_valid ? run_time[OutTimeW-1:0] : '0;
			res.normal_on_y = run_valid ? run_on_y : 1'b0;
			res.normal_negative = run_valid ? run_negative : 1'b0;
			res.target_index = run_valid ? run_position[PosW-1:0] : '0;
			expected_q.push_back(res);
			run_valid = 0;
			run_time = 0;
			run_on_y = 0;
			run_negative = 0;
			run_position = 0;
			target_count = 0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t e;
		if (!arst_n) begin
			expected_q.delete();
			fail_count <= 0;
			run_valid = 0;
			run_time = 0;
			run_on_y = 0;
			run_negative = 0;
			run_position = 0;
			target_count = 0;
		end else begin
			if (req_valid && req_ready) predict_hit(req_data);
			if (rsp_valid && rsp_ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result %p", $time, rsp_data);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_q.pop_front();
					if (e.hit_found !== rsp_data.hit_found)
						$display("%0t: hit_found expected %0d got %0d", $time,
							e.hit_found, rsp_data.hit_found);
					if (e.hit_time !== rsp_data.hit_time)
						$display("%0t: hit_time expected %0d got %0d", $time,
							e.hit_time, rsp_data.hit_time);
					if (e.normal_on_y !== rsp_data.normal_on_y)
						$display("%0t: normal_on_y expected %0d got %0d", $time,
							e.normal_on_y, rsp_data.normal_on_y);
					if (e.normal_negative !== rsp_data.normal_negative)
						$display("%0t: normal_negative expected %0d got %0d", $time,
							e.normal_negative, rsp_data.normal_negative);
					if (e.target_index !== rsp_data.target_index)
						$display("%0t: target_index expected %0d got %0d", $time,
							e.target_index, rsp_data.target_index);
					if (e !== rsp_data) fail_count <= fail_count + 1;
				end
			end
		end
	end
endmodule
`default_nettype wire

FILE: tb/tb_swept_box_earliest_hit.sv
// Testbench top for the swept box earliest hit block: drives directed and random
// target runs under varied idling. Depends on sbeh_pkg, sbeh_if and tb_sbeh_checker.
`default_nettype none
module tb_swept_box_earliest_hit;
	import sbeh_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending;
	int   sent = 0;
	int   mode = 0;
	logic hold_long = 1'b0;
	longint cycles = 0;

	sbeh_if #(.payload_t(req_t)) req_ch (clk);
	sbeh_if #(.payload_t(rsp_t)) rsp_ch (clk);

	swept_box_earliest_hit u_top (
		.clk(clk), .arst_n(arst_n), .req(req_ch.sink), .rsp(rsp_ch.source)
	);

	tb_sbeh_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_data(req_ch.data),
		.rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_data(rsp_ch.data),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2500000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// The receiver stalls according to the current phase, and once holds off
	// for a long stretch so that the block backs up into its input.
	initial begin
		int hold;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_long) begin
				hold_long = 1'b0;
				rsp_ch.ready = 1'b0;
				for (hold = 0; hold < 4000; hold++) @(negedge clk);
			end
			case (mode)
				2:       rsp_ch.ready = $urandom_range(99) >= 87;
				3:       rsp_ch.ready = $urandom_range(99) >= 12;
				default: rsp_ch.ready = 1'b1;
			endcase
		end
	end

	function automatic logic [CoordW-1:0] clip24(input longint v);
		if (v > 8388607) return 24'sd8388607;
		if (v < -8388608) return -24'sd8388608;
		return v[CoordW-1:0];
	endfunction

	function automatic req_t make_req(input longint mnx, mny, mxx, mxy, vx, vy,
			tnx, tny, txx, txy, input logic last);
		req_t r;
		r.mover_min_x = clip24(mnx);
		r.mover_min_y = clip24(mny);
		r.mover_max_x = clip24(mxx);
		r.mover_max_y = clip24(mxy);
		r.velocity_x = clip24(vx);
		r.velocity_y = clip24(vy);
		r.target_min_x = clip24(tnx);
		r.target_min_y = clip24(tny);
		r.target_max_x = clip24(txx);
		r.target_max_y = clip24(txy);
		r.last_target = last;
		return r;
	endfunction

	task automatic send_req(input req_t r);
		while ((mode == 1 && $urandom_range(99) < 87) ||
				(mode == 3 && $urandom_range(99) < 12)) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.data = r;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		sent++;
	endtask

	function automatic longint rand_vel();
		case ($urandom_range(7))
			0:       return 0;
			1:       return longint'($urandom_range(8388607)) - 4194304;
			default: return longint'($urandom_range(8192)) - 4096;
		endcase
	endfunction

	initial begin
		req_t   r;
		longint bx, by, w, h, vx, vy, ox, oy;
		int     len, k;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Extremes of every field.
		send_req(make_req(-8388608, -8388608, 8388607, 8388607, 8388607, -8388608,
			-8388608, -8388608, 8388607, 8388607, 1));
		send_req(make_req(8388607, 8388607, -8388608, -8388608, -8388608, 8388607,
			8388607, 8388607, -8388608, -8388608, 1));
		send_req(make_req(-8388608, 0, -8388600, 256, 8388607, 0,
			8388000, 0, 8388607, 256, 1));
		// Zero velocity on x, overlapping, moving on y into the target.
		send_req(make_req(0, 0, 256, 256, 0, 512, 128, 384, 512, 640, 1));
		// Zero velocity on x with the boxes only touching: rejected.
		send_req(make_req(0, 0, 256, 256, 0, 512, 256, 384, 512, 640, 1));
		// Both axes still and overlapped: time zero, struck on y.
		send_req(make_req(0, 0, 256, 256, 0, 0, 128, 128, 512, 512, 1));
		// Starting overlapped while moving.
		send_req(make_req(0, 0, 256, 256, 300, -200, 100, 100, 400, 400, 1));
		// Negative velocity striking on x.
		send_req(make_req(1024, 0, 1280, 256, -1024, -10, 0, -512, 512, 512, 1));
		// Equal entry on both axes.
		send_req(make_req(0, 0, 256, 256, 512, 512, 512, 512, 768, 768, 1));
		// Two identical hits, the first kept over the second, then an earlier one that wins.
		send_req(make_req(0, 0, 256, 256, 1024, 0, 512, 0, 768, 256, 0));
		send_req(make_req(0, 0, 256, 256, 1024, 0, 512, 0, 768, 256, 0));
		send_req(make_req(0, 0, 256, 256, 1024, 0, 384, 0, 768, 256, 1));
		// A run with no hit: moving away and beyond reach.
		send_req(make_req(0, 0, 256, 256, -256, 0, 512, 0, 768, 256, 0));
		send_req(make_req(0, 0, 256, 256, 256, 0, 4096, 0, 5000, 256, 1));
		// Exit exactly at zero and entry exactly at one.
		send_req(make_req(512, 0, 768, 256, 256, 0, 0, 0, 512, 256, 0));
		send_req(make_req(0, 0, 256, 256, 256, 0, 512, 0, 768, 256, 1));

		while (sent < 1900) begin
			if (sent >= 475 && mode == 0) mode = 1;
			if (sent >= 950 && mode == 1) begin
				mode = 2;
				hold_long = 1'b1;
			end
			if (sent >= 1425 && mode == 2) mode = 3;
			len = $urandom_range(3) == 0 ? $urandom_range(1, 30) : $urandom_range(1, 5);
			bx = longint'($urandom_range(4194304)) - 2097152;
			by = longint'($urandom_range(4194304)) - 2097152;
			w = $urandom_range(1, 4096);
			h = $urandom_range(1, 4096);
			vx = rand_vel();
			vy = rand_vel();
			for (k = 0; k < len; k++) begin
				if ($urandom_range(3) == 0) begin
					r.mover_min_x = CoordW'($urandom);
					r.mover_min_y = CoordW'($urandom);
					r.mover_max_x = CoordW'($urandom);
					r.mover_max_y = CoordW'($urandom);
					r.velocity_x = CoordW'($urandom);
					r.velocity_y = CoordW'($urandom);
					r.target_min_x = CoordW'($urandom);
					r.target_min_y = CoordW'($urandom);
					r.target_max_x = CoordW'($urandom);
					r.target_max_y = CoordW'($urandom);
				end else if (k == 0 || $urandom_range(5) != 0) begin
					ox = bx + (vx * longint'($urandom_range(400))) / 256 +
						longint'($urandom_range(2 * w)) - w;
					oy = by + (vy * longint'($urandom_range(400))) / 256 +
						longint'($urandom_range(2 * h)) - h;
					r = make_req(bx, by, bx + w, by + h, vx, vy, ox, oy,
						ox + $urandom_range(1, 4096), oy + $urandom_range(1, 4096), 0);
				end
				r.last_target = (k == len - 1);
				send_req(r);
			end
		end
		req_ch.valid = 1'b0;
		mode = 0;

		while (pending != 0) @(negedge clk);
		repeat (400) @(negedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
`default_nettype wire
